@@ design/dd_pkg.sv @@
// shared constants, types and calendar tables for the date difference block
`default_nettype none

package dd_pkg;

  localparam int DayW   = 5;
  localparam int MonthW = 4;
  localparam int YearW  = 14;
  localparam int DiffW  = 23;

  // shifted year: year + 400 at most, fits 15 bits
  localparam int YyW    = YearW + 1;
  localparam int EraW   = 6;
  localparam int YoeW   = 9;
  localparam int DoyW   = 9;
  localparam int DoeW   = 18;
  localparam int DnW    = 23;

  // reciprocal of 400: floor(x * Recip400 / 2^Recip400Shift) == x / 400 for x < 2^15
  localparam int Recip400Shift = 23;
  localparam logic [YyW-1:0] Recip400 = 15'd20972;
  localparam int ProdW = 2 * YyW;

  localparam logic [MonthW-1:0] MONTH_FEB = 4'd2;
  localparam logic [DayW-1:0]   FEB_LEAP_LEN = 5'd29;

  localparam logic [EraW+18-1:0] DAYS_PER_ERA = 24'd146097;

  localparam logic signed [DiffW:0] DIFF_MAX = 24'sd4194303;
  localparam logic signed [DiffW:0] DIFF_MIN = -24'sd4194304;

  typedef struct packed {
    logic           valid;
    logic [DnW-1:0] dn;
  } date_num_t;

  // days in month, zero for a month code outside 1 to 12
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m);
    logic [DayW-1:0] len;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // days from march 1 to the first of the month, year starting in march
  function automatic logic [DoyW-1:0] month_offset(input logic [MonthW-1:0] m);
    logic [DoyW-1:0] ofs;
    case (m)
      4'd3:    ofs = 9'd0;
      4'd4:    ofs = 9'd31;
      4'd5:    ofs = 9'd61;
      4'd6:    ofs = 9'd92;
      4'd7:    ofs = 9'd122;
      4'd8:    ofs = 9'd153;
      4'd9:    ofs = 9'd184;
      4'd10:   ofs = 9'd214;
      4'd11:   ofs = 9'd245;
      4'd12:   ofs = 9'd275;
      4'd1:    ofs = 9'd306;
      4'd2:    ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

`default_nettype wire

@@ design/dd_day_number.sv @@
// four-stage pipeline: date validity and proleptic day number
`default_nettype none

module dd_day_number
  import dd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [DayW-1:0]   day,
  input  wire logic [MonthW-1:0] month,
  input  wire logic [YearW-1:0]  year,
  output date_num_t              result
);

  // stage 1: shifted year and quotients by 400
  logic [YyW-1:0]    yy_nxt;
  logic [ProdW-1:0]  era_prod, yq_prod;
  logic [YyW-1:0]    s1_yy_r;
  logic [EraW-1:0]   s1_era_r, s1_yq_r;
  logic [YearW-1:0]  s1_year_r;
  logic [DayW-1:0]   s1_day_r;
  logic [MonthW-1:0] s1_month_r;

  always_comb begin
    yy_nxt   = YyW'(year) + YyW'(400) - ((month <= MONTH_FEB) ? YyW'(1) : YyW'(0));
    era_prod = ProdW'(yy_nxt) * ProdW'(Recip400);
    yq_prod  = ProdW'(year) * ProdW'(Recip400);
  end

  always_ff @(posedge clk) begin
    s1_yy_r    <= yy_nxt;
    s1_era_r   <= era_prod[Recip400Shift +: EraW];
    s1_yq_r    <= yq_prod[Recip400Shift +: EraW];
    s1_year_r  <= year;
    s1_day_r   <= day;
    s1_month_r <= month;
  end

  // stage 2: remainders, leap year, validity, day of year
  logic [YyW-1:0]   yoe_full, r400_full;
  logic [YoeW-1:0]  r400;
  logic             leap;
  logic [DayW-1:0]  len;
  logic [YoeW-1:0]  s2_yoe_r;
  logic [EraW-1:0]  s2_era_r;
  logic [DoyW-1:0]  s2_doy_r;
  logic             s2_valid_r;
  logic             valid_nxt;
  logic [DoyW-1:0]  doy_nxt;

  always_comb begin
    yoe_full  = s1_yy_r - YyW'(s1_era_r) * YyW'(400);
    r400_full = YyW'(s1_year_r) - YyW'(s1_yq_r) * YyW'(400);
    r400      = r400_full[YoeW-1:0];
    // divisible by 4, and a century only when divisible by 400
    leap      = (s1_year_r[1:0] == 2'b00) &&
                (r400 != 9'd100) && (r400 != 9'd200) && (r400 != 9'd300);
    len       = (s1_month_r == MONTH_FEB && leap) ? FEB_LEAP_LEN : month_len(s1_month_r);
    valid_nxt = (s1_day_r != '0) && (s1_day_r <= len);
    doy_nxt   = month_offset(s1_month_r) + DoyW'(s1_day_r) - DoyW'(1);
  end

  always_ff @(posedge clk) begin
    s2_yoe_r   <= yoe_full[YoeW-1:0];
    s2_era_r   <= s1_era_r;
    s2_doy_r   <= doy_nxt;
    s2_valid_r <= valid_nxt;
  end

  // stage 3: day of era and era offset
  logic [1:0]        cent;
  logic [DoeW-1:0]   doe_nxt;
  logic [EraW+17:0]  era_days;
  logic [DoeW-1:0]   s3_doe_r;
  logic [DnW-1:0]    s3_era_days_r;
  logic              s3_valid_r;

  always_comb begin
    cent     = 2'((s2_yoe_r >= 9'd100) ? 1 : 0) + 2'((s2_yoe_r >= 9'd200) ? 1 : 0)
             + 2'((s2_yoe_r >= 9'd300) ? 1 : 0);
    doe_nxt  = DoeW'(s2_yoe_r) * DoeW'(365) + DoeW'(s2_yoe_r >> 2) - DoeW'(cent)
             + DoeW'(s2_doy_r);
    era_days = (EraW+18)'(s2_era_r) * DAYS_PER_ERA;
  end

  always_ff @(posedge clk) begin
    s3_doe_r      <= doe_nxt;
    s3_era_days_r <= era_days[DnW-1:0];
    s3_valid_r    <= s2_valid_r;
  end

  // stage 4: day number
  date_num_t s4_r;

  always_ff @(posedge clk) begin
    s4_r.dn    <= s3_era_days_r + DnW'(s3_doe_r);
    s4_r.valid <= s3_valid_r;
  end

  assign result = s4_r;

endmodule

`default_nettype wire

@@ design/dd_diff.sv @@
// final stage: subtract day numbers, saturate, zero on invalid date
`default_nettype none

module dd_diff
  import dd_pkg::*;
(
  input  wire logic                    clk,
  input  wire date_num_t               first,
  input  wire date_num_t               second,
  output logic                         first_valid,
  output logic                         second_valid,
  output logic signed [DiffW-1:0]      day_difference
);

  logic signed [DiffW:0]   raw;
  logic signed [DiffW-1:0] diff_nxt;
  logic                    first_valid_r, second_valid_r;
  logic signed [DiffW-1:0] diff_r;

  always_comb begin
    raw = $signed({1'b0, second.dn}) - $signed({1'b0, first.dn});
    if (!(first.valid && second.valid)) begin
      diff_nxt = '0;
    end else if (raw > DIFF_MAX) begin
      diff_nxt = DIFF_MAX[DiffW-1:0];
    end else if (raw < DIFF_MIN) begin
      diff_nxt = DIFF_MIN[DiffW-1:0];
    end else begin
      diff_nxt = raw[DiffW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    first_valid_r  <= first.valid;
    second_valid_r <= second.valid;
    diff_r         <= diff_nxt;
  end

  assign first_valid    = first_valid_r;
  assign second_valid   = second_valid_r;
  assign day_difference = diff_r;

endmodule

`default_nettype wire

@@ design/date_difference_days_top.sv @@
// top level of the gregorian date difference block
`default_nettype none

// Takes two Gregorian dates per transaction and reports whether each is a real
// calendar date plus the signed day count from the first date to the second
// (zero when either date is invalid, saturated to the 23-bit signed range).
// A transaction is taken on any clock edge where start is high outside reset;
// busy never rises, so one date pair can enter every cycle. Each result
// appears on the out_ ports for exactly one cycle, flagged by out_valid;
// results come out in the order the transactions went in. The receiver
// cannot stall: it must take each result in the cycle it is shown. The
// work is split over a five-stage pipeline: reciprocal multiply by 400,
// remainder and validity check, day-of-era and era offset, day number sum,
// and the final subtract with saturation. Years are not range checked: any
// 14-bit value, year 0 included, is taken as a proleptic Gregorian year.
module date_difference_days_top
  import dd_pkg::*;
(
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [DayW-1:0]         in_first_day,
  input  wire logic [MonthW-1:0]       in_first_month,
  input  wire logic [YearW-1:0]        in_first_year,
  input  wire logic [DayW-1:0]         in_second_day,
  input  wire logic [MonthW-1:0]       in_second_month,
  input  wire logic [YearW-1:0]        in_second_year,
  output logic                         out_valid,
  output logic                         out_first_valid,
  output logic                         out_second_valid,
  output logic signed [DiffW-1:0]      out_day_difference
);

  localparam int Stages = 5;

  // the pipeline never stalls, so a transaction is always welcome
  assign busy = 1'b0;

  // one valid bit per stage, travelling alongside the data
  logic [Stages-1:0] vld_r, vld_nxt;

  always_comb begin
    vld_nxt = {vld_r[Stages-2:0], start};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // day numbers for both dates, computed side by side
  date_num_t first_num, second_num;

  dd_day_number u_first (
    .clk    (clk),
    .day    (in_first_day),
    .month  (in_first_month),
    .year   (in_first_year),
    .result (first_num)
  );

  dd_day_number u_second (
    .clk    (clk),
    .day    (in_second_day),
    .month  (in_second_month),
    .year   (in_second_year),
    .result (second_num)
  );

  // difference stage drives the registered result fields
  dd_diff u_diff (
    .clk            (clk),
    .first          (first_num),
    .second         (second_num),
    .first_valid    (out_first_valid),
    .second_valid   (out_second_valid),
    .day_difference (out_day_difference)
  );

  assign out_valid = vld_r[Stages-1];

endmodule

`default_nettype wire

@@ design/dd_checker.sv @@
// port-level checks for the date difference block, bound to the top level
`default_nettype none

module dd_checker
  import dd_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   start,
  input wire logic                   busy,
  input wire logic                   out_valid,
  input wire logic                   out_first_valid,
  input wire logic                   out_second_valid,
  input wire logic signed [DiffW-1:0] out_day_difference
);

  // the block takes a transaction every cycle
  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  // every accepted transaction yields a result flagged by out_valid
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##5 out_valid)
    else $error("result missing for accepted transaction");

  // no result without an earlier accepted transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && rst_n, 5))
    else $error("result without a transaction");

  // an invalid date forces a zero difference
  a_zero_on_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !(out_first_valid && out_second_valid)) |-> (out_day_difference == '0))
    else $error("nonzero difference with an invalid date");

endmodule

bind date_difference_days_top dd_checker u_dd_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .start              (start),
  .busy               (busy),
  .out_valid          (out_valid),
  .out_first_valid    (out_first_valid),
  .out_second_valid   (out_second_valid),
  .out_day_difference (out_day_difference)
);

`default_nettype wire
